// File: src/pad_pkg.sv
`timescale 1ns / 1ps

package pad_pkg;

  // Full-scale output level. Kept a power of two so the delay scaling is a shift.
  localparam int unsigned FULL_SCALE = 1024;
  localparam int unsigned VRANGE_LOG2 = $clog2(FULL_SCALE);

  // Default width of the wrapping tick counter (16 to 32).
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned LEVEL_WIDTH  = 11;
  localparam int unsigned DELAY_WIDTH  = $clog2(FULL_SCALE + 1);
  localparam int unsigned PERIOD_WIDTH = 32;

  localparam int unsigned S_TDATA_WIDTH = 8;
  localparam int unsigned M_TDATA_WIDTH = ((1 + PERIOD_WIDTH + 7) / 8) * 8;

endpackage

// File: src/phase_angle_dimmer.sv
`timescale 1ns / 1ps

// A result is registered and appears on m_axis in the cycle after its tick item is accepted.
// Throughput: one item per cycle while m_axis_tready is high; the delay multiply, the firing-tick sum and
// the firing compare all sit in the single stage ahead of the result register.
// Reset (rst_ni low, asynchronous): counter, pulse marks, firing tick, period and
// gate clear to zero, the level clears to zero (full delay), no result is pending.
module phase_angle_dimmer #(
  parameter int unsigned COUNT_WIDTH = pad_pkg::COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Level register write port.
  input  logic                                cfg_we_i,
  input  logic [pad_pkg::LEVEL_WIDTH-1:0]     cfg_wdata_i,
  // Tick items in.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pad_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,  // [0] sync_level, rest zero
  // Results out.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pad_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata   // [0] gate, [32:1] period_ticks
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned DW   = pad_pkg::DELAY_WIDTH;
  localparam int unsigned PW   = pad_pkg::PERIOD_WIDTH;
  localparam int unsigned MW   = pad_pkg::M_TDATA_WIDTH;
  localparam int unsigned PRW  = CW + DW;
  localparam int unsigned SHFT = pad_pkg::VRANGE_LOG2;

  logic [DW-1:0] delay_q;
  logic [CW-1:0] tick_q, pulse_start_q, pulse_end_q, fire_q, period_q, half_q;
  logic          prev_sync_q, gate_q;
  logic [CW-1:0] tick_d, pulse_start_d, pulse_end_d, fire_d, period_d, half_d;
  logic          prev_sync_d, gate_d;

  logic          m_valid_q;
  logic [MW-1:0] m_data_q;

  logic          accept;
  logic          sync;
  logic          rising, falling;
  logic [PRW-1:0] product;
  logic [CW-1:0]  offs;
  logic [CW-1:0]  width_diff, width_sum;

  // The result register frees up whenever its item is taken in the same cycle.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sync          = s_axis_tdata[0];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Level is held as the firing delay, already clamped to full scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DW'(pad_pkg::FULL_SCALE);
    end else if (cfg_we_i) begin
      if (32'(cfg_wdata_i) >= pad_pkg::FULL_SCALE) begin
        delay_q <= '0;
      end else begin
        delay_q <= DW'(pad_pkg::FULL_SCALE - 32'(cfg_wdata_i));
      end
    end
  end

  always_comb begin
    tick_d        = tick_q + CW'(1);
    rising        = sync && !prev_sync_q;
    falling       = !sync && prev_sync_q;
    prev_sync_d   = sync;
    pulse_start_d = rising ? tick_d : pulse_start_q;
    pulse_end_d   = falling ? tick_d : pulse_end_q;
    period_d      = rising ? (tick_d - pulse_start_q) : period_q;

    product = PRW'(delay_q) * PRW'(period_d);
    offs    = product[SHFT +: CW];

    // half_q always holds the halved width of the most recent pulse marks.
    fire_d = rising ? (tick_d + half_q + offs) : fire_q;

    // Signed half of the new width, rounded toward zero.
    width_diff = pulse_end_d - pulse_start_d;
    width_sum  = width_diff + CW'(width_diff[CW-1]);
    half_d     = {width_sum[CW-1], width_sum[CW-1:1]};

    gate_d = rising ? 1'b0 : gate_q;
    if (tick_d == fire_d) begin
      gate_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      pulse_start_q <= '0;
      pulse_end_q   <= '0;
      fire_q        <= '0;
      period_q      <= '0;
      half_q        <= '0;
      prev_sync_q   <= 1'b0;
      gate_q        <= 1'b0;
    end else if (accept) begin
      tick_q        <= tick_d;
      pulse_start_q <= pulse_start_d;
      pulse_end_q   <= pulse_end_d;
      fire_q        <= fire_d;
      period_q      <= period_d;
      half_q        <= half_d;
      prev_sync_q   <= prev_sync_d;
      gate_q        <= gate_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= MW'({PW'(period_d), gate_d});
    end
  end

endmodule

// File: bench/phase_angle_dimmer_tb.sv
`timescale 1ns / 1ps

module phase_angle_dimmer_tb;

  typedef struct packed {
    logic        gate;
    logic [31:0] period;
  } dimmer_out_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [pad_pkg::LEVEL_WIDTH-1:0]    cfg_wdata_i = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [pad_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata = '0;   // [0] sync_level, rest zero
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [pad_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata;        // [0] gate, [32:1] period_ticks

  phase_angle_dimmer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the dimmer state, advanced once per accepted tick.
  logic [31:0]                     ticks_m = '0;
  logic [31:0]                     rise_at_m = '0;
  logic [31:0]                     fall_at_m = '0;
  logic [31:0]                     fire_at_m = '0;
  logic [31:0]                     period_m = '0;
  logic                            sync_m = 1'b0;
  logic                            gate_m = 1'b0;
  logic [pad_pkg::LEVEL_WIDTH-1:0] level_m = '0;

  dimmer_out_t due_outputs[$];
  dimmer_out_t due;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  int unsigned ticks_sent = 0;
  int unsigned outputs_seen = 0;
  int unsigned gate_on_seen = 0;
  int unsigned level_writes = 0;
  int unsigned err_cnt = 0;

  function automatic dimmer_out_t advance_dimmer(input logic sync);
    logic [pad_pkg::LEVEL_WIDTH-1:0] lv;
    logic [31:0]                     delay;
    logic [63:0]                     prod;
    logic signed [31:0]              width;
    logic signed [31:0]              half;
    dimmer_out_t                     res;
    ticks_m = ticks_m + 32'd1;
    if (sync != sync_m) begin
      if (sync) begin
        gate_m = 1'b0;
        lv = (level_m > pad_pkg::FULL_SCALE) ?
             pad_pkg::LEVEL_WIDTH'(pad_pkg::FULL_SCALE) : level_m;
        delay = pad_pkg::FULL_SCALE - 32'(lv);
        period_m = ticks_m - rise_at_m;
        prod = 64'(delay) * 64'(period_m);
        // Signed division truncates toward zero, as the block's halving does.
        width = $signed(fall_at_m - rise_at_m);
        half = width / 2;
        fire_at_m = ticks_m + 32'(half) + 32'(prod / 64'(pad_pkg::FULL_SCALE));
        rise_at_m = ticks_m;
      end else begin
        fall_at_m = ticks_m;
      end
      sync_m = sync;
    end
    if (ticks_m == fire_at_m) gate_m = 1'b1;
    res.gate = gate_m;
    res.period = period_m;
    return res;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: result with none expected: gate %0b period %0d", $time,
                 m_axis_tdata[0], m_axis_tdata[32:1]);
        err_cnt++;
      end else begin
        due = due_outputs.pop_front();
        outputs_seen++;
        if (m_axis_tdata[0] === 1'b1) gate_on_seen++;
        if (m_axis_tdata[0] !== due.gate) begin
          $display("%0t: gate mismatch: expected %0b actual %0b", $time, due.gate,
                   m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[32:1] !== due.period) begin
          $display("%0t: period_ticks mismatch: expected %0d actual %0d", $time,
                   due.period, m_axis_tdata[32:1]);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_tick(input logic sync);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(pad_pkg::S_TDATA_WIDTH-1){1'b0}}, sync};
    do @(posedge clk_i); while (!s_axis_tready);
    due_outputs.push_back(advance_dimmer(sync));
    ticks_sent++;
  endtask

  task automatic send_run(input logic sync, input int unsigned count);
    repeat (count) send_tick(sync);
  endtask

  // Stop offering items and wait until every predicted output has come back.
  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_level(input logic [pad_pkg::LEVEL_WIDTH-1:0] value);
    settle_outputs();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    level_m = value;
    level_writes++;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [pad_pkg::LEVEL_WIDTH-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return pad_pkg::LEVEL_WIDTH'(pad_pkg::FULL_SCALE);
      2: return '1;
      3: return pad_pkg::LEVEL_WIDTH'($urandom_range(pad_pkg::FULL_SCALE + 1, 2047));
      default: return pad_pkg::LEVEL_WIDTH'($urandom_range(1, pad_pkg::FULL_SCALE - 1));
    endcase
  endfunction

  // Mains-like sync waveform with random pulse and gap lengths.
  task automatic send_waveform(input int unsigned count);
    int unsigned hi_max;
    int unsigned lo_max;
    int unsigned left;
    int unsigned len;
    hi_max = $urandom_range(1, 12);
    lo_max = $urandom_range(1, 40);
    left = count;
    while (left != 0) begin
      len = $urandom_range(1, hi_max);
      if (len > left) len = left;
      send_run(1'b1, len);
      left -= len;
      len = $urandom_range(1, lo_max);
      if (len > left) len = left;
      send_run(1'b0, len);
      left -= len;
    end
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) send_tick(1'($urandom_range(1)));
  endtask

  task automatic run_random_segments();
    repeat (4) begin
      set_level(pick_level());
      send_waveform(55);
      send_noise(12);
    end
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_run(1'b0, 2);
    // Full level with no earlier pulse: the gate fires on the rising edge itself.
    set_level(pad_pkg::LEVEL_WIDTH'(pad_pkg::FULL_SCALE));
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    // Levels above full scale are clamped to full scale.
    set_level('1);
    send_run(1'b1, 2);
    send_run(1'b0, 3);
    // Zero level gives the longest delay of a whole period plus half a pulse.
    set_level('0);
    send_run(1'b1, 1);
    send_run(1'b0, 6);
    set_level(pad_pkg::LEVEL_WIDTH'(pad_pkg::FULL_SCALE / 2));
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    settle_outputs();
  endtask

  task automatic test_random_free();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    run_random_segments();
  endtask

  task automatic test_random_source_gaps();
    src_idle_pct = 81;
    snk_stall_pct = 0;
    run_random_segments();
  endtask

  task automatic test_random_sink_stalls();
    src_idle_pct = 0;
    snk_stall_pct = 81;
    run_random_segments();
  endtask

  task automatic test_random_both();
    src_idle_pct = 36;
    snk_stall_pct = 36;
    run_random_segments();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_level(pad_pkg::LEVEL_WIDTH'($urandom_range(200, 900)));
    // The receiver holds off long enough for the block to fill and refuse items.
    hold_req = 300;
    send_waveform(40);
    settle_outputs();
    send_waveform(30);
    settle_outputs();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_free();
    test_random_source_gaps();
    test_random_sink_stalls();
    test_random_both();
    test_backpressure();
    repeat (5) @(posedge clk_i);
    $display("Sent %0d tick items over %0d level settings; %0d outputs checked,",
             ticks_sent, level_writes, outputs_seen);
    $display("gate seen on in %0d of them, with idle, stall and hold-off phases.",
             gate_on_seen);
    if (err_cnt == 0) begin
      $display("phase_angle_dimmer_tb OK");
    end else begin
      $display("phase_angle_dimmer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d outputs still expected.", due_outputs.size());
    $display("phase_angle_dimmer_tb NOT OK");
    $finish;
  end

endmodule

// File: phase_angle_dimmer.f
src/pad_pkg.sv
src/phase_angle_dimmer.sv
bench/phase_angle_dimmer_tb.sv
